/* hw/rtl/serial_frame_receiver_defines.svh */
// ---------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/sfr_pkg.sv */
// ---------------------------------------------------------------------------
// Serial frame receiver package
// Shared types, framing constants and the ones' complement adder.
// ---------------------------------------------------------------------------
package sfr_pkg;

   // Framing constants.
   localparam logic [7:0] SYNC_FIRST   = 8'h42;
   localparam logic [7:0] SYNC_SECOND  = 8'h53;
   localparam logic [7:0] HARD_MIN_LEN = 8'd8;
   localparam logic [7:0] HARD_MAX_LEN = 8'd64;
   localparam logic [5:0] HEADER_BYTES = 6'd3;
   localparam logic [15:0] SUM_GOOD    = 16'hFFFF;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 7;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LENGTH = 1'b1;
   localparam logic [CSR_DATA_WIDTH-1:0]  MIN_LENGTH_RESET = 7'd8;
   localparam logic [CSR_DATA_WIDTH-1:0]  MAX_LENGTH_RESET = 7'd64;

   // Receiver phase.
   typedef enum logic [1:0] {
      PH_HUNT1  = 2'd0,
      PH_HUNT2  = 2'd1,
      PH_LENGTH = 2'd2,
      PH_BODY   = 2'd3
   } sfr_phase_type;

   // One buffered input transaction.
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } sfr_in_type;

   // Length limits from the configuration registers.
   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] min_length;
      logic [CSR_DATA_WIDTH-1:0] max_length;
   } sfr_len_cfg_type;

   // Ones' complement 16-bit addition with end-around carry.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[15:0] + {15'd0, sum[16]};
   endfunction

endpackage

/* hw/rtl/sfr_csr.sv */
// ---------------------------------------------------------------------------
// Serial frame receiver configuration registers
// Holds the minimum and maximum accepted frame length.
// ---------------------------------------------------------------------------
module sfr_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [sfr_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sfr_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   output sfr_pkg::sfr_len_cfg_type               len_cfg
);
   import sfr_pkg::*;

   logic [CSR_DATA_WIDTH-1:0] min_length_ff;
   logic [CSR_DATA_WIDTH-1:0] max_length_ff;
   logic [CSR_DATA_WIDTH-1:0] min_length_in;
   logic [CSR_DATA_WIDTH-1:0] max_length_in;

   // Register write decode.
   always_comb begin
      min_length_in = min_length_ff;
      max_length_in = max_length_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_LENGTH: min_length_in = csr_wdata;
            CSR_MAX_LENGTH: max_length_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         min_length_ff <= min_length_in;
         max_length_ff <= max_length_in;
      end
   end

   assign len_cfg.min_length = min_length_ff;
   assign len_cfg.max_length = max_length_ff;

endmodule

/* hw/rtl/sfr_input_stage.sv */
// ---------------------------------------------------------------------------
// Serial frame receiver input stage
// Registers each incoming byte transaction ahead of the parser.
// ---------------------------------------------------------------------------
module sfr_input_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  logic                 advance,
   output sfr_pkg::sfr_in_type  in_item
);
   import sfr_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] in_byte_in;

   // The stage is blocked only while it holds a byte the parser cannot take.
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   assign in_item.valid   = in_valid_ff;
   assign in_item.rx_byte = in_byte_ff;

endmodule

/* hw/rtl/sfr_parser.sv */
// ---------------------------------------------------------------------------
// Serial frame receiver parser
// Sync hunt, length check, checksum and frame id, with the result register.
// ---------------------------------------------------------------------------
`include "serial_frame_receiver_defines.svh"

module sfr_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  sfr_pkg::sfr_in_type       in_item,
   input  sfr_pkg::sfr_len_cfg_type  len_cfg,
   output logic                      advance,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_data_byte,
   output logic [5:0]                rsp_position,
   output logic                      rsp_last_of_frame,
   output logic                      rsp_checksum_ok,
   output logic [15:0]               rsp_frame_id
);
   import sfr_pkg::*;

   // Frame state.
   sfr_phase_type phase_ff, phase_in;
   logic [5:0]  bytes_left_ff, bytes_left_in;
   logic [5:0]  byte_index_ff, byte_index_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  held_low_ff, held_low_in;
   logic        pair_half_ff, pair_half_in;
   logic [7:0]  id_high_ff, id_high_in;
   logic [7:0]  id_low_ff, id_low_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [5:0]  rsp_pos_ff, rsp_pos_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [15:0] rsp_id_ff, rsp_id_in;

   logic        process;
   logic [7:0]  b;
   logic        len_ok;
   logic        last;
   logic [15:0] pair_sum;
   logic [15:0] final_sum;

   // The result register frees up when it is empty or being taken.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign process = in_item.valid && advance;
   assign b       = in_item.rx_byte;

   assign len_ok = (b >= HARD_MIN_LEN) && (b <= HARD_MAX_LEN) &&
                   (b >= {1'b0, len_cfg.min_length}) && (b <= {1'b0, len_cfg.max_length});
   assign last   = (bytes_left_ff == 6'd1);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (process) begin
         unique case (phase_ff)
            PH_HUNT1:  if (b == SYNC_FIRST) phase_in = PH_HUNT2;
            PH_HUNT2:  phase_in = (b == SYNC_SECOND) ? PH_LENGTH : PH_HUNT1;
            PH_LENGTH: phase_in = len_ok ? PH_BODY : PH_HUNT1;
            PH_BODY:   if (last) phase_in = PH_HUNT1;
            default:   phase_in = PH_HUNT1;
         endcase
      end
   end

   // Frame datapath and result outputs.
   always_comb begin
      bytes_left_in  = bytes_left_ff;
      byte_index_in  = byte_index_ff;
      running_sum_in = running_sum_ff;
      held_low_in    = held_low_ff;
      pair_half_in   = pair_half_ff;
      id_high_in     = id_high_ff;
      id_low_in      = id_low_ff;

      pair_sum  = ones_add(running_sum_ff, {b, held_low_ff});
      final_sum = running_sum_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_id_in    = rsp_id_ff;

      if (process && phase_ff == PH_LENGTH && len_ok) begin
         // Seed the frame: sync pair summed, length byte waits for its partner.
         bytes_left_in  = b[5:0] - HEADER_BYTES;
         byte_index_in  = HEADER_BYTES;
         running_sum_in = {SYNC_SECOND, SYNC_FIRST};
         held_low_in    = b;
         pair_half_in   = 1'b1;
      end

      if (process && phase_ff == PH_BODY) begin
         if (byte_index_ff == 6'd3) id_high_in = b;
         if (byte_index_ff == 6'd4) id_low_in = b;

         if (pair_half_ff) begin
            running_sum_in = pair_sum;
            pair_half_in   = 1'b0;
         end else begin
            held_low_in  = b;
            pair_half_in = 1'b1;
         end

         // A trailing odd byte enters the sum with a zero high byte.
         final_sum = pair_half_in ? ones_add(running_sum_in, {8'h00, held_low_in})
                                  : running_sum_in;

         bytes_left_in = bytes_left_ff - 6'd1;
         byte_index_in = byte_index_ff + 6'd1;

         rsp_valid_in = 1'b1;
         rsp_data_in  = b;
         rsp_pos_in   = byte_index_ff;
         rsp_last_in  = last;
         rsp_ok_in    = last && (final_sum == SUM_GOOD);
         rsp_id_in    = last ? {id_high_ff, id_low_ff} : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT1;
         bytes_left_ff <= 6'd0;
         byte_index_ff <= 6'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         byte_index_ff <= byte_index_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      running_sum_ff <= running_sum_in;
      held_low_ff    <= held_low_in;
      pair_half_ff   <= pair_half_in;
      id_high_ff     <= id_high_in;
      id_low_ff      <= id_low_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_id_ff      <= rsp_id_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = rsp_data_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_last_of_frame = rsp_last_ff;
   assign rsp_checksum_ok   = rsp_ok_ff;
   assign rsp_frame_id      = rsp_id_ff;

   // Checks on frame bookkeeping.
   `SFR_ASSERT_NOW(a_body_has_bytes, phase_ff == PH_BODY, bytes_left_ff != 6'd0, "body with no bytes left")
   `SFR_ASSERT_NEXT(a_last_rehunts, process && phase_ff == PH_BODY && last, phase_ff == PH_HUNT1, "no rehunt after last byte")
   `SFR_ASSERT_NOW(a_fields_zero, rsp_valid_ff && !rsp_last_ff, !rsp_ok_ff && rsp_id_ff == 16'h0000, "frame fields set before last")
   `SFR_ASSERT_NOW(a_position_floor, rsp_valid_ff, rsp_pos_ff >= HEADER_BYTES, "result inside the header")

endmodule

/* hw/rtl/serial_frame_receiver.sv */
// ---------------------------------------------------------------------------
// Serial frame receiver
// Sync/length framed byte receiver with a ones' complement frame checksum.
// ---------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  rx_byte
//   rsp      out        rsp_valid/rsp_stall  data_byte, position, last_of_frame,
//                                            checksum_ok, frame_id
//   csr      in         csr_write            csr_index, csr_wdata
//
// One byte is taken per cycle while req_stall is low; a byte reaches rsp through
// the input register, then the parser's result register.
// Reset is synchronous: the receiver hunts for the first sync byte and the length
// limits return to 8 and 64.
// rsp_stall holds the result register; req_stall rises only while the input
// register is full and the result register cannot load.
// ---------------------------------------------------------------------------
module serial_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_data_byte,
   output logic [5:0]                           rsp_position,
   output logic                                 rsp_last_of_frame,
   output logic                                 rsp_checksum_ok,
   output logic [15:0]                          rsp_frame_id,
   input  logic                                 csr_write,
   input  logic [sfr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sfr_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import sfr_pkg::*;

   sfr_in_type      in_item;
   sfr_len_cfg_type len_cfg;
   logic            advance;

   sfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .len_cfg   (len_cfg)
   );

   sfr_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .in_item     (in_item)
   );

   sfr_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .in_item           (in_item),
      .len_cfg           (len_cfg),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_position      (rsp_position),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_frame_id      (rsp_frame_id)
   );

endmodule
